// ===== rtl/ttsd_pkg.sv =====
// Shared definitions for the temporary table statement detector.
// Parse phase codes, keyword text, queue sizing and the character helpers.
// No dependencies.
package ttsd_pkg;

    // Parse phases
    localparam logic [4:0] PH_LEAD      = 5'd0;
    localparam logic [4:0] PH_DASH      = 5'd1;
    localparam logic [4:0] PH_COMMENT   = 5'd2;
    localparam logic [4:0] PH_WS2       = 5'd3;
    localparam logic [4:0] PH_CREATE    = 5'd4;
    localparam logic [4:0] PH_WS_A      = 5'd5;
    localparam logic [4:0] PH_LOCAL     = 5'd6;
    localparam logic [4:0] PH_GLOBAL    = 5'd7;
    localparam logic [4:0] PH_WS_B      = 5'd8;
    localparam logic [4:0] PH_TEMP      = 5'd9;
    localparam logic [4:0] PH_WS_C      = 5'd10;
    localparam logic [4:0] PH_TABLE     = 5'd11;
    localparam logic [4:0] PH_NAME_WAIT = 5'd12;
    localparam logic [4:0] PH_NAME      = 5'd13;
    localparam logic [4:0] PH_DONE      = 5'd14;

    // Keyword text, first character in the top byte
    localparam logic [47:0] KW_CREATE    = "create";
    localparam logic [39:0] KW_LOCAL     = "local";
    localparam logic [47:0] KW_GLOBAL    = "global";
    localparam logic [71:0] KW_TEMPORARY = "temporary";
    localparam logic [39:0] KW_TABLE     = "table";

    localparam logic [3:0] TEMP_SHORT_LEN = 4'd4;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_O     = 8'h6F;

    // Result queue
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic       last;
        logic [7:0] ch;
    } out_word_t;

    typedef struct packed {
        logic [4:0] phase;
        logic [3:0] pos;
    } kw_res_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB);
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [3:0] kw_len(input logic [4:0] ph);
        logic [3:0] n;
        unique case (ph)
            PH_CREATE: n = 4'd6;
            PH_LOCAL:  n = 4'd5;
            PH_GLOBAL: n = 4'd6;
            PH_TEMP:   n = 4'd9;
            PH_TABLE:  n = 4'd5;
            default:   n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [4:0] kw_next(input logic [4:0] ph);
        logic [4:0] n;
        unique case (ph)
            PH_CREATE: n = PH_WS_A;
            PH_LOCAL:  n = PH_WS_B;
            PH_GLOBAL: n = PH_WS_B;
            PH_TEMP:   n = PH_WS_C;
            PH_TABLE:  n = PH_NAME_WAIT;
            default:   n = PH_DONE;
        endcase
        return n;
    endfunction

    // Expected character at a position; zero beyond the word's end
    function automatic logic [7:0] kw_char(input logic [4:0] ph, input logic [3:0] pos);
        logic [7:0] c;
        c = 8'h00;
        if (pos < kw_len(ph)) begin
            unique case (ph)
                PH_CREATE: c = KW_CREATE[8 * (5 - int'(pos)) +: 8];
                PH_LOCAL:  c = KW_LOCAL[8 * (4 - int'(pos)) +: 8];
                PH_GLOBAL: c = KW_GLOBAL[8 * (5 - int'(pos)) +: 8];
                PH_TEMP:   c = KW_TEMPORARY[8 * (8 - int'(pos)) +: 8];
                PH_TABLE:  c = KW_TABLE[8 * (4 - int'(pos)) +: 8];
                default:   c = 8'h00;
            endcase
        end
        return c;
    endfunction

    // One step of keyword matching on a folded character
    function automatic kw_res_t kw_match(input logic [4:0] ph, input logic [3:0] pos,
                                         input logic [7:0] lc);
        kw_res_t r;
        logic [3:0] len;
        len = kw_len(ph);
        r.phase = ph;
        r.pos   = pos;
        if (len == 4'd0) begin
            r.phase = PH_DONE;
        end else if (ph == PH_TEMP && pos == TEMP_SHORT_LEN && lc != CH_O) begin
            // plain "temp": this character already follows the word
            r.pos = 4'd0;
            if (is_ws(lc)) begin
                r.phase = PH_WS_C;
            end else if (lc == CH_T) begin
                r.phase = PH_TABLE;
                r.pos   = 4'd1;
            end else begin
                r.phase = PH_DONE;
            end
        end else if (pos < len && lc == kw_char(ph, pos)) begin
            if (pos + 4'd1 >= len) begin
                r.phase = kw_next(ph);
                r.pos   = 4'd0;
            end else begin
                r.pos = pos + 4'd1;
            end
        end else begin
            r.phase = PH_DONE;
            r.pos   = 4'd0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/temp_table_statement_detector_unit.sv =====
// Top level of the temporary table statement detector.
// Parser state machine and result queue; depends on ttsd_pkg.
//
// Usage:
//   The slave channel takes one query character per word on s_tdata, with
//   s_tlast high on the final character of the query. The master channel
//   gives the characters of the table name of a "create [local|global]
//   temp[orary] table <name>" statement, one per word, m_tlast marking the
//   last character of the name. Queries of any other form give nothing.
//   Throughput: one character per cycle while s_tready is high. Each
//   accepted character is decided in the cycle it is accepted and its
//   results are registered into a four-word result queue, which offers them
//   in order (a name character is held back until its successor shows
//   whether it ends the name). A query ending inside a name can release two
//   words at once; s_tready drops only while the queue has room for fewer
//   than two words, so a stalled receiver backs up into the sender once
//   three or more words are queued.
//   Reset (aresetn low at a clock edge) returns the parser to the leading
//   whitespace phase and empties the queue. The parser also returns to that
//   phase after every character marked last.
module temp_table_statement_detector_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] name_char
    output logic       m_tlast
);

    logic [4:0] phase_reg, phase_next;
    logic [3:0] pos_reg, pos_next;
    logic [7:0] held_char_reg, held_char_next;
    logic       held_valid_reg, held_valid_next;

    ttsd_pkg::out_word_t mem_reg [ttsd_pkg::QDEPTH];
    logic [ttsd_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [ttsd_pkg::QCNT_W-1:0] count_reg, count_next;

    logic                in_acc, out_acc;
    logic [7:0]          lc;
    logic                ws;
    logic [1:0]          push_n;
    ttsd_pkg::out_word_t e0, e1;
    ttsd_pkg::kw_res_t   kw;

    assign in_acc = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;
    assign lc = ttsd_pkg::fold(s_tdata);
    assign ws = ttsd_pkg::is_ws(s_tdata);

    // Decide one character: next parse state and up to two result words
    always_comb begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        push_n          = 2'd0;
        e0              = '{last: 1'b0, ch: held_char_reg};
        e1              = '{last: 1'b1, ch: s_tdata};
        kw              = '{phase: phase_reg, pos: pos_reg};
        unique case (phase_reg)
            ttsd_pkg::PH_LEAD: begin
                if (!ws) begin
                    if (s_tdata == ttsd_pkg::CH_DASH) begin
                        phase_next = ttsd_pkg::PH_DASH;
                    end else begin
                        kw         = ttsd_pkg::kw_match(ttsd_pkg::PH_CREATE, 4'd0, lc);
                        phase_next = kw.phase;
                        pos_next   = kw.pos;
                    end
                end
            end
            ttsd_pkg::PH_DASH: begin
                phase_next = (s_tdata == ttsd_pkg::CH_DASH) ? ttsd_pkg::PH_COMMENT
                                                            : ttsd_pkg::PH_DONE;
            end
            ttsd_pkg::PH_COMMENT: begin
                if (s_tdata == ttsd_pkg::CH_LF) begin
                    phase_next = ttsd_pkg::PH_WS2;
                end
            end
            ttsd_pkg::PH_WS2: begin
                if (!ws) begin
                    kw         = ttsd_pkg::kw_match(ttsd_pkg::PH_CREATE, 4'd0, lc);
                    phase_next = kw.phase;
                    pos_next   = kw.pos;
                end
            end
            ttsd_pkg::PH_WS_A: begin
                if (!ws) begin
                    if (lc == ttsd_pkg::CH_L) begin
                        kw = ttsd_pkg::kw_match(ttsd_pkg::PH_LOCAL, 4'd0, lc);
                    end else if (lc == ttsd_pkg::CH_G) begin
                        kw = ttsd_pkg::kw_match(ttsd_pkg::PH_GLOBAL, 4'd0, lc);
                    end else if (lc == ttsd_pkg::CH_T) begin
                        kw = ttsd_pkg::kw_match(ttsd_pkg::PH_TEMP, 4'd0, lc);
                    end else begin
                        kw.phase = ttsd_pkg::PH_DONE;
                    end
                    phase_next = kw.phase;
                    pos_next   = kw.pos;
                end
            end
            ttsd_pkg::PH_WS_B, ttsd_pkg::PH_WS_C: begin
                if (!ws) begin
                    if (lc == ttsd_pkg::CH_T) begin
                        kw = ttsd_pkg::kw_match(
                            (phase_reg == ttsd_pkg::PH_WS_B) ? ttsd_pkg::PH_TEMP
                                                             : ttsd_pkg::PH_TABLE,
                            4'd0, lc);
                        phase_next = kw.phase;
                        pos_next   = kw.pos;
                    end else begin
                        phase_next = ttsd_pkg::PH_DONE;
                    end
                end
            end
            ttsd_pkg::PH_CREATE, ttsd_pkg::PH_LOCAL, ttsd_pkg::PH_GLOBAL,
            ttsd_pkg::PH_TEMP, ttsd_pkg::PH_TABLE: begin
                kw         = ttsd_pkg::kw_match(phase_reg, pos_reg, lc);
                phase_next = kw.phase;
                pos_next   = kw.pos;
            end
            ttsd_pkg::PH_NAME_WAIT: begin
                if (!ws) begin
                    if (s_tlast) begin
                        push_n = 2'd1;
                        e0     = '{last: 1'b1, ch: s_tdata};
                    end else begin
                        held_char_next  = s_tdata;
                        held_valid_next = 1'b1;
                    end
                    phase_next = ttsd_pkg::PH_NAME;
                end
            end
            ttsd_pkg::PH_NAME: begin
                if (ws) begin
                    // whitespace ends the name: release the held word as last
                    if (held_valid_reg) begin
                        push_n = 2'd1;
                        e0     = '{last: 1'b1, ch: held_char_reg};
                    end
                    held_valid_next = 1'b0;
                    phase_next      = ttsd_pkg::PH_DONE;
                end else begin
                    if (held_valid_reg && s_tlast) begin
                        push_n = 2'd2;
                    end else if (held_valid_reg) begin
                        push_n = 2'd1;
                    end else if (s_tlast) begin
                        push_n = 2'd1;
                        e0     = '{last: 1'b1, ch: s_tdata};
                    end
                    if (s_tlast) begin
                        held_valid_next = 1'b0;
                    end else begin
                        held_char_next  = s_tdata;
                        held_valid_next = 1'b1;
                    end
                end
            end
            default: begin
                phase_next = ttsd_pkg::PH_DONE;
            end
        endcase
        // end of query: back to the reset state
        if (s_tlast) begin
            phase_next      = ttsd_pkg::PH_LEAD;
            pos_next        = 4'd0;
            held_char_next  = 8'h00;
            held_valid_next = 1'b0;
        end
        if (!in_acc) begin
            push_n = 2'd0;
        end
    end

    // Advance the parser on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= ttsd_pkg::PH_LEAD;
            pos_reg        <= 4'd0;
            held_char_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
        end else if (in_acc) begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
        end
    end

    // Result queue: push up to two words, pop one
    assign count_next = count_reg + ttsd_pkg::QCNT_W'(push_n)
                      - ttsd_pkg::QCNT_W'(out_acc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + ttsd_pkg::QPTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + ttsd_pkg::QPTR_W'(out_acc);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= e0;
        end
        if (push_n == 2'd2) begin
            mem_reg[wr_ptr_reg + ttsd_pkg::QPTR_W'(1)] <= e1;
        end
    end

    // Hold off the sender unless two free slots remain
    assign s_tready = (count_reg <= ttsd_pkg::QCNT_W'(ttsd_pkg::QDEPTH - 2));
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = mem_reg[rd_ptr_reg].ch;
    assign m_tlast  = mem_reg[rd_ptr_reg].last;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ttsd_pkg::QCNT_W'(ttsd_pkg::QDEPTH))
        else $error("result queue overflow");

    a_query_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_tlast) |=> (phase_reg == ttsd_pkg::PH_LEAD && !held_valid_reg))
        else $error("parser not back to leading phase after query end");

    a_held_in_name: assert property (@(posedge aclk) disable iff (!aresetn)
        held_valid_reg |-> (phase_reg == ttsd_pkg::PH_NAME))
        else $error("held character outside name phase");

    a_stall_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (count_reg >= $past(count_reg)))
        else $error("result word lost while stalled");

endmodule
